// ===== design/cftt_pkg.sv =====
// ----------------------------------------------------------------------------
// cftt_pkg: shared types and constants for the colour fade track table
// Holds the track entry layout, operation and channel codes, the sequencer
// states and the arithmetic widths used by the blend datapath and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package cftt_pkg;

	// Number of fade tracks held in the table (1 to 64).
	localparam int TRACKS    = 8;
	localparam int TRK_W     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int TIDX_W    = 8;

	// Field widths.
	localparam int TICKS_W   = 32;
	localparam int DUR_W     = 16;
	localparam int RGB_W     = 24;
	localparam int CH_W      = 8;
	localparam int FTK_W     = 16;

	// 32 ticks per frame.
	localparam int FRAC_BITS = 5;
	localparam logic [TICKS_W-1:0] ARM_TICKS = TICKS_W'(32);

	// Whole frames elapsed, remaining frames, blend numerator and its magnitude.
	localparam int FRM_W     = TICKS_W - FRAC_BITS;
	localparam int REM_W     = FRM_W + 1;
	localparam int NUM_W     = REM_W + CH_W + 2;
	localparam int MAG_W     = NUM_W - 1;
	localparam int DIV_CNT_W = $clog2(MAG_W);

	typedef enum logic [1:0] {
		FUNC_ARM  = 2'd0,
		FUNC_STEP = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		CHAN_RED   = 2'd0,
		CHAN_GREEN = 2'd1,
		CHAN_BLUE  = 2'd2,
		CHAN_NONE  = 2'd3
	} chan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_SUM,
		ST_START,
		ST_DIV,
		ST_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TICKS_W-1:0] ticks;
		logic [DUR_W-1:0]   dur;
		logic [RGB_W-1:0]   start_rgb;
		logic [RGB_W-1:0]   end_rgb;
		logic [RGB_W-1:0]   cur_rgb;
	} track_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [TRK_W-1:0] addr;
		track_t           wr_data;
	} store_req_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [DUR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [CH_W-1:0] quot_low;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== design/cftt_track_store.sv =====
// ----------------------------------------------------------------------------
// cftt_track_store: per-track state memory
// Reads and writes share one address and read data is registered. Per-entry
// valid bits make an entry that was never armed read back as all zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module cftt_track_store
	import cftt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_req_t req,
	output track_t          rd_data
);

	track_t              mem_q [TRACKS];
	track_t              rd_raw_q;
	logic [TRACKS-1:0]   valid_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem_q[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : '0;

endmodule

`default_nettype wire

// ===== design/cftt_divider.sv =====
// ----------------------------------------------------------------------------
// cftt_divider: iterative unsigned restoring divider
// Divides the blend numerator magnitude by the ramp length magnitude, one
// quotient bit per cycle, and returns the low byte of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module cftt_divider
	import cftt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DUR_W-1:0]     part_q;
	logic [MAG_W-1:0]     quo_q;
	logic [DUR_W-1:0]     dsr_q;

	logic [DUR_W:0]       shifted;
	logic [DUR_W+1:0]     diff;
	logic                 fits;

	assign shifted = {part_q, quo_q[MAG_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
	assign fits    = !diff[DUR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(MAG_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			part_q <= '0;
			quo_q  <= req.dividend;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			part_q <= fits ? diff[DUR_W-1:0] : shifted[DUR_W-1:0];
			quo_q  <= {quo_q[MAG_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quot_low = quo_q[CH_W-1:0];

endmodule

`default_nettype wire

// ===== design/colour_fade_track_table_top.sv =====
// Flow: arm, read, no-operation and refused step transactions go from ST_LOAD
//   to ST_DONE; a blending step runs ST_MUL to ST_DIV per channel, then ST_WB.
// One transaction at a time; the next is taken once the sequencer is in ST_IDLE.
//   A blending step uses the shared divider for each colour channel in turn:
//   ST_MUL and ST_SUM form the numerator, ST_START starts the divider.
// Reset: arst_n clears the sequencer, the handshakes and every track to zero.
// ----------------------------------------------------------------------------
// colour_fade_track_table_top: table of linear colour fade tracks
// A small sequencer runs one transaction at a time against the track memory.
// A step blends start and end colour per channel through one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module colour_fade_track_table_top
	import cftt_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              func,
	input  wire logic [TIDX_W-1:0]       track_index,
	input  wire logic [RGB_W-1:0]        start_colour,
	input  wire logic [RGB_W-1:0]        end_colour,
	input  wire logic signed [DUR_W-1:0] duration_frames,
	input  wire logic [FTK_W-1:0]        frame_ticks,
	input  wire logic [1:0]              channel_select,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic                         step_ok,
	output logic                         finished,
	output logic [CH_W-1:0]              channel_value
);

	state_t state_q;
	state_t state_d;

	// Captured transaction.
	func_t             func_q;
	logic [TRK_W-1:0]  trk_q;
	logic [RGB_W-1:0]  start_q;
	logic [RGB_W-1:0]  endc_q;
	logic [DUR_W-1:0]  dur_in_q;
	logic [FTK_W-1:0]  fticks_q;
	chan_t             chsel_q;

	// Blend datapath.
	track_t                   entry_q;
	logic signed [FRM_W-1:0]  frm_q;
	logic signed [REM_W-1:0]  rem_q;
	chan_t                    chan_q;
	logic signed [NUM_W-1:0]  prod_s_q;
	logic signed [NUM_W-1:0]  prod_e_q;
	logic signed [NUM_W-1:0]  num_q;
	logic                     qneg_q;
	logic [RGB_W-1:0]         next_rgb_q;

	// Pending result and output register.
	logic            res_ok_q;
	logic            res_fin_q;
	logic [CH_W-1:0] res_val_q;
	logic            out_valid_q;
	logic            ok_q;
	logic            fin_q;
	logic [CH_W-1:0] val_q;

	store_req_t store_req;
	track_t     rd_entry;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	logic                    accept;
	logic                    out_load;
	logic [TRK_W-1:0]        trk_map;
	logic signed [TICKS_W-1:0] ticks_rd;
	logic [TICKS_W-1:0]      ticks_biased;
	logic signed [FRM_W-1:0] frm_d;
	logic signed [REM_W-1:0] rem_d;
	logic signed [CH_W:0]    s_op;
	logic signed [CH_W:0]    e_op;
	logic signed [NUM_W-1:0] prod_s;
	logic signed [NUM_W-1:0] prod_e;
	logic [NUM_W-1:0]        num_mag;
	logic [DUR_W-1:0]        dur_mag;
	logic [CH_W-1:0]         chan_byte;
	logic [TICKS_W-1:0]      ticks_new;
	logic signed [TICKS_W-1:0] dur_ticks;
	logic                    fin_d;
	logic [CH_W-1:0]         read_byte;
	track_t                  arm_entry;
	track_t                  step_entry;

	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Out-of-range track indexes fall back to track 0.
	assign trk_map = (track_index < TIDX_W'(TRACKS)) ? track_index[TRK_W-1:0] : '0;

	// Whole frames elapsed, truncated toward zero: bias negative counts by 31
	// before the arithmetic shift.
	assign ticks_rd     = rd_entry.ticks;
	assign ticks_biased = rd_entry.ticks
		+ {{(TICKS_W-FRAC_BITS){1'b0}}, {FRAC_BITS{ticks_rd[TICKS_W-1]}}};
	assign frm_d = ticks_biased[TICKS_W-1:FRAC_BITS];
	assign rem_d = {{(REM_W-DUR_W){rd_entry.dur[DUR_W-1]}}, rd_entry.dur}
		- {frm_d[FRM_W-1], frm_d};

	// One channel of the blend numerator: start*(duration-frames) + end*frames.
	assign s_op   = {1'b0, entry_q.start_rgb[chan_q*CH_W +: CH_W]};
	assign e_op   = {1'b0, entry_q.end_rgb[chan_q*CH_W +: CH_W]};
	assign prod_s = s_op * rem_q;
	assign prod_e = e_op * frm_q;

	// The divider works on magnitudes; the quotient sign is restored on its
	// low byte, which is all that is kept.
	assign num_mag   = num_q[NUM_W-1] ? -num_q : num_q;
	assign dur_mag   = entry_q.dur[DUR_W-1] ? -entry_q.dur : entry_q.dur;
	assign chan_byte = qneg_q ? -div_rsp.quot_low : div_rsp.quot_low;

	// Tick counter advance and end-of-ramp test, signed on 32 bits.
	assign ticks_new = entry_q.ticks + {{(TICKS_W-FTK_W){1'b0}}, fticks_q};
	assign dur_ticks = {{(TICKS_W-DUR_W-FRAC_BITS){entry_q.dur[DUR_W-1]}},
		entry_q.dur, {FRAC_BITS{1'b0}}};
	assign fin_d     = dur_ticks < $signed(ticks_new);

	always_comb begin
		case (chsel_q)
			CHAN_RED:   read_byte = rd_entry.cur_rgb[0*CH_W +: CH_W];
			CHAN_GREEN: read_byte = rd_entry.cur_rgb[1*CH_W +: CH_W];
			CHAN_BLUE:  read_byte = rd_entry.cur_rgb[2*CH_W +: CH_W];
			default:    read_byte = '0;
		endcase
	end

	assign arm_entry = '{
		ticks:     ARM_TICKS,
		dur:       dur_in_q,
		start_rgb: start_q,
		end_rgb:   endc_q,
		cur_rgb:   start_q
	};

	assign step_entry = '{
		ticks:     ticks_new,
		dur:       entry_q.dur,
		start_rgb: entry_q.start_rgb,
		end_rgb:   entry_q.end_rgb,
		cur_rgb:   next_rgb_q
	};

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshake and the requests to the memory and the divider.
	always_comb begin
		state_d           = state_q;
		in_ready          = 1'b0;
		store_req.rd_en   = 1'b0;
		store_req.wr_en   = 1'b0;
		store_req.addr    = trk_q;
		store_req.wr_data = step_entry;
		div_req.start     = 1'b0;
		div_req.dividend  = num_mag[MAG_W-1:0];
		div_req.divisor   = dur_mag;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				store_req.addr = trk_map;
				if (in_valid) begin
					store_req.rd_en = 1'b1;
					state_d         = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_DONE;
				if (func_q == FUNC_ARM) begin
					store_req.wr_en   = 1'b1;
					store_req.wr_data = arm_entry;
				end else if (func_q == FUNC_STEP && rd_entry.dur != '0) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_START;
			end
			ST_START: begin
				div_req.start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = (chan_q == CHAN_BLUE) ? ST_WB : ST_MUL;
				end
			end
			ST_WB: begin
				store_req.wr_en = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func_t'(func);
			trk_q    <= trk_map;
			start_q  <= start_colour;
			endc_q   <= end_colour;
			dur_in_q <= duration_frames;
			fticks_q <= frame_ticks;
			chsel_q  <= chan_t'(channel_select);
		end
		case (state_q)
			ST_LOAD: begin
				entry_q   <= rd_entry;
				frm_q     <= frm_d;
				rem_q     <= rem_d;
				chan_q    <= CHAN_RED;
				res_ok_q  <= 1'b0;
				res_fin_q <= 1'b0;
				res_val_q <= (func_q == FUNC_READ) ? read_byte : '0;
			end
			ST_MUL: begin
				prod_s_q <= prod_s;
				prod_e_q <= prod_e;
			end
			ST_SUM: begin
				num_q <= prod_s_q + prod_e_q;
			end
			ST_START: begin
				qneg_q <= num_q[NUM_W-1] ^ entry_q.dur[DUR_W-1];
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					next_rgb_q[chan_q*CH_W +: CH_W] <= chan_byte;
					chan_q <= chan_t'(chan_q + 2'd1);
				end
			end
			ST_WB: begin
				res_ok_q  <= 1'b1;
				res_fin_q <= fin_d;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			ok_q  <= res_ok_q;
			fin_q <= res_fin_q;
			val_q <= res_val_q;
		end
	end

	// Output register valid: a finished transaction waits in ST_DONE until the
	// previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign step_ok       = ok_q;
	assign finished      = fin_q;
	assign channel_value = val_q;

	cftt_track_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (store_req),
		.rd_data (rd_entry)
	);

	cftt_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

`default_nettype wire

// ===== design/cftt_checker.sv =====
// ----------------------------------------------------------------------------
// cftt_checker: port-level checks for the colour fade track table
// Watches the top-level ports only and is attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module cftt_checker
	import cftt_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic                    step_ok,
	input wire logic                    finished,
	input wire logic [CH_W-1:0]         channel_value
);

	// Only one transaction is in flight: the block is busy right after taking one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a transaction was in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(step_ok)
			&& $stable(finished) && $stable(channel_value))
		else $error("stalled result changed or dropped");

	a_fin_needs_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> step_ok)
		else $error("finished reported without a completed step");

	a_step_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && step_ok |-> channel_value == '0)
		else $error("step result carries a channel value");

endmodule

bind colour_fade_track_table_top cftt_checker u_cftt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.step_ok       (step_ok),
	.finished      (finished),
	.channel_value (channel_value)
);

`default_nettype wire
